// ===== hdl/c_keyword_token_counter_top_defines.svh =====
// ----------------------------------------------------------------------------
// Keyword token counter assertion macros
// Shorthand for clocked checks that are disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef C_KEYWORD_TOKEN_COUNTER_TOP_DEFINES_SVH
`define C_KEYWORD_TOKEN_COUNTER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ktc_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyword token counter package
// Transfer types, lexer and control state codes, and the keyword table.
// ----------------------------------------------------------------------------
package ktc_pkg;

  localparam int unsigned TABLE_SIZE = 14;

  typedef enum logic [1:0] {
    KIND_HIT    = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_EMPTY  = 2'd2
  } ktc_kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_WORD    = 3'd1,
    MODE_SLASH   = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_STAR    = 3'd4,
    MODE_STRING  = 3'd5
  } ktc_lex_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HIT_RD,
    ST_HIT_WR,
    ST_REP_RD,
    ST_REP_OUT,
    ST_REP_EMPTY
  } ktc_state_e;

  typedef struct packed {
    logic       action;
    logic [7:0] char_code;
  } ktc_in_t;

  typedef struct packed {
    ktc_kind_e   kind;
    logic [3:0]  keyword_index;
    logic [15:0] hit_count;
    logic        last;
  } ktc_out_t;

  // Keyword characters, first character in the lowest byte, zero padded.
  localparam logic [63:0] KW_CHARS [TABLE_SIZE] = '{
    64'h0065_6e69_6665_6423,  // #define
    64'h6564_756c_636e_6923,  // #include
    64'h0000_0000_6f74_7561,  // auto
    64'h0000_006b_6165_7262,  // break
    64'h0000_0000_6573_6163,  // case
    64'h0000_0000_7261_6863,  // char
    64'h0000_0074_736e_6f63,  // const
    64'h6575_6e69_746e_6f63,  // continue
    64'h0074_6c75_6166_6564,  // default
    64'h0000_0000_0072_6f66,  // for
    64'h6465_6e67_6973_6e75,  // unsigned
    64'h0000_0000_6469_6f76,  // void
    64'h656c_6974_616c_6f76,  // volatile
    64'h0000_0065_6c69_6877   // while
  };

  localparam logic [3:0] KW_LEN [TABLE_SIZE] = '{
    4'd7, 4'd8, 4'd4, 4'd5, 4'd4, 4'd4, 4'd5,
    4'd8, 4'd7, 4'd3, 4'd8, 4'd4, 4'd8, 4'd5
  };

endpackage

// ===== hdl/c_keyword_token_counter_top.sv =====
// ----------------------------------------------------------------------------
// Keyword token counter: a character that ends a keyword is counted by reading its count and
// writing it back through one single-port RAM; the input is stalled meanwhile. A report emits
// one entry per nonzero count, stepping past zero entries below the last nonzero one, or a
// single empty entry when no count is set; output stalls hold it. Reset idles the lexer and
// clears per-entry valid bits; the RAM needs no clearing pass.
// ----------------------------------------------------------------------------
`include "c_keyword_token_counter_top_defines.svh"

module c_keyword_token_counter_top
  import ktc_pkg::*;
#(
  parameter int unsigned KEYWORD_COUNT = 14,
  parameter int unsigned MAX_KEY_CHARS = 8,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ktc_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ktc_out_t out_data_o
);

  localparam int unsigned NUM_KEYS = (KEYWORD_COUNT < TABLE_SIZE) ? KEYWORD_COUNT : TABLE_SIZE;
  localparam int unsigned IDX_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned WORD_W   = 8 * MAX_KEY_CHARS;
  localparam int unsigned LEN_W    = $clog2(MAX_KEY_CHARS + 2);
  localparam int unsigned EXT_W    = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  ktc_state_e              state_q, state_d;
  ktc_lex_mode_e           mode_q, mode_d;
  logic [WORD_W-1:0]       word_q, word_d;
  logic [LEN_W-1:0]        len_q, len_d;
  logic [IDX_W-1:0]        hit_idx_q, hit_idx_d;
  logic                    report_q;
  logic [IDX_W-1:0]        rep_idx_q, rep_idx_d;
  logic [NUM_KEYS-1:0]     cnt_vld_q;
  logic [COUNT_BITS-1:0]   count_mem [NUM_KEYS];
  logic [COUNT_BITS-1:0]   rdata_q;
  logic                    out_valid_q;
  ktc_out_t                out_data_q;

  logic                    in_xfer;
  logic                    slot_free;
  logic                    finish;
  logic                    is_report;
  logic                    hit;
  logic [7:0]              c;
  logic                    is_alpha, is_digit, starts_word;
  logic [WORD_W-1:0]       word_app;
  logic                    len_ok;
  logic                    more_above;
  logic [COUNT_BITS-1:0]   cnt_cur, cnt_new;
  logic [EXT_W-1:0]        cnt_ext;

  logic                    mem_re, mem_we, out_load, rep_step;
  ktc_kind_e               out_kind;
  logic                    out_last;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign c           = in_data_i.char_code;
  assign is_report   = in_data_i.action;
  assign is_alpha    = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_digit    = (c >= "0" && c <= "9");
  assign starts_word = is_alpha || (c == "_") || (c == "#");
  assign len_ok      = (len_q != '0) && (len_q <= LEN_W'(MAX_KEY_CHARS));

  always_comb begin
    word_app = word_q;
    for (int j = 0; j < MAX_KEY_CHARS; j++) begin
      if (LEN_W'(j) == len_q) begin
        word_app[8*j +: 8] = c;
      end
    end
  end

  always_comb begin
    hit       = 1'b0;
    hit_idx_d = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (!hit && len_ok && (word_q == KW_CHARS[k][WORD_W-1:0]) &&
          (4'(len_q) == KW_LEN[k])) begin
        hit       = 1'b1;
        hit_idx_d = IDX_W'(k);
      end
    end
  end

  always_comb begin
    mode_d = mode_q;
    word_d = word_q;
    len_d  = len_q;
    finish = 1'b0;
    if (is_report) begin
      finish = (mode_q == MODE_WORD);
      mode_d = MODE_IDLE;
      word_d = '0;
      len_d  = '0;
    end else begin
      case (mode_q)
        MODE_WORD: begin
          if (is_alpha || is_digit || c == "_") begin
            if (len_q < LEN_W'(MAX_KEY_CHARS)) begin
              word_d = word_app;
              len_d  = len_q + 1'b1;
            end else begin
              len_d = LEN_W'(MAX_KEY_CHARS + 1);
            end
          end else begin
            finish = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (c == "*") begin
            mode_d = MODE_COMMENT;
          end
        end
        MODE_COMMENT: begin
          if (c == "*") begin
            mode_d = MODE_STAR;
          end
        end
        MODE_STAR: begin
          if (c == "/") begin
            mode_d = MODE_IDLE;
          end else if (c != "*") begin
            mode_d = MODE_COMMENT;
          end
        end
        MODE_STRING: begin
          if (c == "\"") begin
            mode_d = MODE_IDLE;
          end
        end
        default: begin
        end
      endcase
      // A character seen outside a word, including after an ended word or a lone slash.
      if (finish || (mode_q == MODE_SLASH && c != "*") ||
          (mode_q != MODE_WORD && mode_q != MODE_SLASH && mode_q != MODE_COMMENT &&
           mode_q != MODE_STAR && mode_q != MODE_STRING)) begin
        word_d = '0;
        len_d  = '0;
        if (starts_word) begin
          word_d[7:0] = c;
          len_d       = LEN_W'(1);
          mode_d      = MODE_WORD;
        end else if (c == "/") begin
          mode_d = MODE_SLASH;
        end else if (c == "\"") begin
          mode_d = MODE_STRING;
        end else begin
          mode_d = MODE_IDLE;
        end
      end
    end
  end

  always_comb begin
    more_above = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (k > int'(rep_idx_q) && cnt_vld_q[k]) begin
        more_above = 1'b1;
      end
    end
  end

  assign cnt_cur = cnt_vld_q[hit_idx_q] ? rdata_q : '0;
  assign cnt_new = (cnt_cur == {COUNT_BITS{1'b1}}) ? cnt_cur : cnt_cur + 1'b1;
  assign cnt_ext = EXT_W'((state_q == ST_HIT_WR) ? cnt_new : rdata_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (finish && hit) begin
            state_d = ST_HIT_RD;
          end else if (is_report) begin
            state_d = (cnt_vld_q == '0) ? ST_REP_EMPTY : ST_REP_RD;
          end
        end
      end
      ST_HIT_RD: begin
        state_d = ST_HIT_WR;
      end
      ST_HIT_WR: begin
        if (slot_free) begin
          state_d = report_q ? ST_REP_RD : ST_IDLE;
        end
      end
      ST_REP_RD: begin
        if (cnt_vld_q[rep_idx_q]) begin
          state_d = ST_REP_OUT;
        end
      end
      ST_REP_OUT: begin
        if (slot_free) begin
          state_d = more_above ? ST_REP_RD : ST_IDLE;
        end
      end
      ST_REP_EMPTY: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_re   = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    rep_step = 1'b0;
    out_kind = KIND_HIT;
    out_last = 1'b0;
    case (state_q)
      ST_HIT_RD: begin
        mem_re = 1'b1;
      end
      ST_HIT_WR: begin
        mem_we   = slot_free;
        out_load = slot_free;
        out_kind = KIND_HIT;
        out_last = !report_q;
      end
      ST_REP_RD: begin
        mem_re   = cnt_vld_q[rep_idx_q];
        rep_step = !cnt_vld_q[rep_idx_q];
      end
      ST_REP_OUT: begin
        out_load = slot_free;
        rep_step = slot_free;
        out_kind = KIND_REPORT;
        out_last = !more_above;
      end
      ST_REP_EMPTY: begin
        out_load = slot_free;
        out_kind = KIND_EMPTY;
        out_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rep_idx_d = rep_idx_q;
    if (state_q == ST_IDLE || state_q == ST_HIT_WR) begin
      rep_idx_d = '0;
    end else if (rep_step) begin
      rep_idx_d = rep_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_IDLE;
      word_q      <= '0;
      len_q       <= '0;
      hit_idx_q   <= '0;
      report_q    <= 1'b0;
      rep_idx_q   <= '0;
      cnt_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rep_idx_q <= rep_idx_d;
      if (in_xfer) begin
        mode_q    <= mode_d;
        word_q    <= word_d;
        len_q     <= len_d;
        hit_idx_q <= hit_idx_d;
        report_q  <= is_report;
      end
      if (mem_we) begin
        cnt_vld_q[hit_idx_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.kind          <= out_kind;
      out_data_q.keyword_index <= (out_kind == KIND_HIT)   ? 4'(hit_idx_q) :
                                  (out_kind == KIND_EMPTY) ? 4'd0 : 4'(rep_idx_q);
      out_data_q.hit_count     <= (out_kind == KIND_EMPTY) ? 16'd0 : cnt_ext[15:0];
      out_data_q.last          <= out_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      count_mem[hit_idx_q] <= cnt_new;
    end
    if (mem_re) begin
      rdata_q <= count_mem[(state_q == ST_HIT_RD) ? hit_idx_q : rep_idx_q];
    end
  end

  `KTC_ASSERT_NEXT(a_vld_after_write, mem_we, cnt_vld_q[$past(hit_idx_q)], "Count write did not mark its entry as counted.")
  `KTC_ASSERT_NOW(a_report_counted, out_load && out_kind == KIND_REPORT, cnt_vld_q[rep_idx_q], "Report entry emitted for an uncounted keyword.")
  `KTC_ASSERT_NOW(a_empty_report, out_load && out_kind == KIND_EMPTY, cnt_vld_q == '0, "Empty report emitted while counts are nonzero.")

endmodule
